### design/voice_allocator_adsr_loudest_select_defines.svh
// Assertion macros used by the checker file
`ifndef VOICE_ALLOCATOR_ADSR_LOUDEST_SELECT_DEFINES_SVH
`define VOICE_ALLOCATOR_ADSR_LOUDEST_SELECT_DEFINES_SVH

// Clocked assertion, switched off while reset is high
`define VAS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset
`define VAS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/vas_pkg.sv
package vas_pkg;

   // event codes
   localparam logic [1:0] FUNC_NOTE_ON  = 2'd0;
   localparam logic [1:0] FUNC_NOTE_OFF = 2'd1;
   localparam logic [1:0] FUNC_ALL_OFF  = 2'd2;
   localparam logic [1:0] FUNC_TICK     = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_ATTACK  = 2'd0;
   localparam logic [1:0] CSR_DECAY   = 2'd1;
   localparam logic [1:0] CSR_SUSTAIN = 2'd2;
   localparam logic [1:0] CSR_RELEASE = 2'd3;

   // register reset values
   localparam logic [15:0] ATTACK_RESET  = 16'd50;
   localparam logic [15:0] DECAY_RESET   = 16'd100;
   localparam logic [3:0]  SUSTAIN_RESET = 4'd7;
   localparam logic [15:0] RELEASE_RESET = 16'd200;

   localparam int LEVEL_W   = 17;   // Q1.16 level
   localparam int DUR_W     = 16;
   localparam int NUM_W     = LEVEL_W + DUR_W;
   localparam int DIV_STEPS = LEVEL_W;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 17'h1FFFF;
   localparam logic [3:0] SUSTAIN_MAX = 4'd10;

   typedef struct packed {
      logic [13:0] frequency;
      logic [7:0]  velocity;
      logic [3:0]  channel;
      logic [31:0] start_ms;
      logic [31:0] release_ms;
   } voice_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] dividend;
      logic [DUR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [LEVEL_W-1:0] quotient;
   } div_rsp_type;

   localparam logic [13:0] FREQ_ROM [128] = '{
      14'd0, 14'd8, 14'd9, 14'd9, 14'd10, 14'd10, 14'd11, 14'd12,
      14'd12, 14'd13, 14'd14, 14'd15, 14'd16, 14'd17, 14'd18, 14'd19,
      14'd20, 14'd21, 14'd23, 14'd24, 14'd25, 14'd27, 14'd29, 14'd30,
      14'd32, 14'd34, 14'd36, 14'd38, 14'd41, 14'd43, 14'd46, 14'd48,
      14'd51, 14'd55, 14'd58, 14'd61, 14'd65, 14'd69, 14'd73, 14'd77,
      14'd82, 14'd87, 14'd92, 14'd97, 14'd103, 14'd110, 14'd116, 14'd123,
      14'd130, 14'd138, 14'd146, 14'd155, 14'd164, 14'd174, 14'd184, 14'd195,
      14'd207, 14'd220, 14'd233, 14'd246, 14'd261, 14'd277, 14'd293, 14'd311,
      14'd329, 14'd349, 14'd369, 14'd391, 14'd415, 14'd440, 14'd466, 14'd493,
      14'd523, 14'd554, 14'd587, 14'd622, 14'd659, 14'd698, 14'd739, 14'd783,
      14'd830, 14'd880, 14'd932, 14'd987, 14'd1046, 14'd1108, 14'd1174, 14'd1244,
      14'd1318, 14'd1396, 14'd1479, 14'd1567, 14'd1661, 14'd1760, 14'd1864, 14'd1975,
      14'd2093, 14'd2217, 14'd2349, 14'd2489, 14'd2637, 14'd2793, 14'd2959, 14'd3135,
      14'd3322, 14'd3520, 14'd3729, 14'd3951, 14'd4186, 14'd4434, 14'd4698, 14'd4978,
      14'd5274, 14'd5587, 14'd5919, 14'd6271, 14'd6644, 14'd7040, 14'd7458, 14'd7902,
      14'd8372, 14'd8869, 14'd9397, 14'd9956, 14'd10548, 14'd11175, 14'd11839, 14'd12543
   };

   // velocity/127 in Q1.16: 65536 = 516*127 + 4, so v*65536/127 = 516v + 4v/127
   function automatic logic [LEVEL_W-1:0] base_of(input logic [7:0] vel);
      logic [9:0]  x;
      logic [2:0]  q0;
      logic [7:0]  rr;
      logic [3:0]  q;
      logic [17:0] b;
      x  = {vel, 2'b00};
      q0 = x[9:7];
      rr = {1'b0, x[6:0]} + {5'd0, q0};
      q  = {1'b0, q0} + ((rr >= 8'd127) ? 4'd1 : 4'd0);
      b  = ({10'd0, vel} << 9) + ({10'd0, vel} << 2) + {14'd0, q};
      return (b > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : b[LEVEL_W-1:0];
   endfunction

   // sustain tenths/10 in Q1.16, saturated at ten tenths
   function automatic logic [LEVEL_W-1:0] sustain_of(input logic [3:0] tenths);
      logic [LEVEL_W-1:0] s;
      case (tenths)
         4'd0:    s = 17'd0;
         4'd1:    s = 17'd6553;
         4'd2:    s = 17'd13107;
         4'd3:    s = 17'd19660;
         4'd4:    s = 17'd26214;
         4'd5:    s = 17'd32768;
         4'd6:    s = 17'd39321;
         4'd7:    s = 17'd45875;
         4'd8:    s = 17'd52428;
         4'd9:    s = 17'd58982;
         default: s = 17'd65536;
      endcase
      return s;
   endfunction

endpackage

### design/vas_voice_ram.sv
module vas_voice_ram #(
   parameter int VOICES = 8,
   parameter int AW     = 3
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  vas_pkg::voice_type  wr_data,
   input  logic [AW-1:0]       rd_addr,
   output vas_pkg::voice_type  rd_data
);

   vas_pkg::voice_type mem_ff [VOICES];
   vas_pkg::voice_type rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/vas_divider.sv
module vas_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  vas_pkg::div_req_type req,
   output vas_pkg::div_rsp_type rsp
);

   logic                          run_ff, run_in;
   logic                          done_ff, done_in;
   logic [4:0]                    cnt_ff, cnt_in;
   logic [vas_pkg::DUR_W-1:0]     rem_ff, rem_in;
   logic [vas_pkg::LEVEL_W-1:0]   dvd_ff, dvd_in;
   logic [vas_pkg::DUR_W-1:0]     dsr_ff, dsr_in;
   logic [vas_pkg::DUR_W:0]       trial;
   logic                          ge;

   // restoring division, one quotient bit per cycle; quotient known below 2^17
   always_comb begin
      trial   = {rem_ff, dvd_ff[vas_pkg::LEVEL_W-1]};
      ge      = trial >= {1'b0, dsr_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      if (req.start) begin
         run_in = 1'b1;
         cnt_in = 5'd0;
         rem_in = req.dividend[vas_pkg::NUM_W-1:vas_pkg::LEVEL_W];
         dvd_in = req.dividend[vas_pkg::LEVEL_W-1:0];
         dsr_in = req.divisor;
      end else if (run_ff) begin
         rem_in = ge ? 16'(trial - {1'b0, dsr_ff}) : trial[vas_pkg::DUR_W-1:0];
         dvd_in = {dvd_ff[vas_pkg::LEVEL_W-2:0], ge};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(vas_pkg::DIV_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = dvd_ff;

endmodule

### design/voice_allocator_adsr_loudest_select.sv
// A note on writes its voice, after a start-time scan when no voice is free; note off and tick
// events scan the voices. Then, but for a note on with an invalid channel, the loudest-voice
// scan skips idle voices and takes each active one through the shared bit-serial divider in
// attack, decay or release. Throughput: one transaction at a time, busy high until the result
// strobe. Reset: synchronous, clears all voices and loads the default envelope registers.
// The result strobe rsp_valid lasts one cycle; the receiver cannot stall.
module voice_allocator_adsr_loudest_select #(
   parameter int VOICES         = 8,
   parameter int CHANNELS       = 16,
   parameter int FULL_VOLUME    = 100,
   parameter int VELOCITY_LIMIT = 127
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_func,
   input  logic [3:0]  req_channel,
   input  logic [6:0]  req_note,
   input  logic [7:0]  req_velocity,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   output logic        rsp_playing,
   output logic [13:0] rsp_frequency,
   output logic [6:0]  rsp_volume,
   output logic [3:0]  rsp_channel_out,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int LW = vas_pkg::LEVEL_W;

   typedef enum logic [4:0] {
      IDLE, OLD_RD, OLD_CMP, ON_WR, OFF_RD, OFF_CMP, TICK_RD, TICK_CMP,
      SEL_RD, SEL_LOAD, SEL_SL, SEL_MUL, SEL_DIVGO, SEL_DIV, SEL_FIN, SEL_VOL
   } state_type;

   typedef enum logic [2:0] {
      MODE_ZERO, MODE_SUS, MODE_ATK, MODE_DEC, MODE_REL
   } mode_type;

   state_type            state_ff, state_in;
   mode_type             mode_ff, mode_in;
   logic [VW:0]          idx_ff, idx_in;
   logic [VW-1:0]        cand_ff, cand_in;
   logic [31:0]          oldest_ff, oldest_in;
   logic [VOICES-1:0]    active_ff, active_in;
   logic [VOICES-1:0]    released_ff, released_in;

   // latched transaction
   logic [3:0]           ch_ff, ch_in;
   logic [13:0]          freq_ff, freq_in;
   logic [7:0]           vel_ff, vel_in;
   logic [31:0]          now_ff, now_in;

   // envelope datapath
   logic [LW-1:0]        base_ff, base_in;
   logic [LW-1:0]        sl_ff, sl_in;
   logic [31:0]          e_ff, e_in;
   logic [31:0]          r_ff, r_in;
   logic [13:0]          cur_freq_ff, cur_freq_in;
   logic [3:0]           cur_ch_ff, cur_ch_in;
   logic [15:0]          opb_ff, opb_in;
   logic [15:0]          dsr_ff, dsr_in;
   logic [vas_pkg::NUM_W-1:0] num_ff, num_in;
   logic [LW-1:0]        best_ff, best_in;
   logic [13:0]          best_freq_ff, best_freq_in;
   logic [3:0]           best_ch_ff, best_ch_in;

   // result registers
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_playing_ff, rsp_playing_in;
   logic [13:0]          rsp_freq_ff, rsp_freq_in;
   logic [6:0]           rsp_vol_ff, rsp_vol_in;
   logic [3:0]           rsp_ch_ff, rsp_ch_in;

   // envelope registers
   logic [15:0]          attack_ff, decay_ff, release_ff;
   logic [3:0]           sustain_ff;

   logic                 ram_we;
   logic [VW-1:0]        ram_waddr;
   vas_pkg::voice_type   ram_wdata;
   vas_pkg::voice_type   ram_rdata;
   vas_pkg::div_req_type div_req;
   vas_pkg::div_rsp_type div_rsp;

   logic [VW-1:0]        cur;
   logic                 last;
   logic                 has_free;
   logic [VW-1:0]        free_idx;
   logic [LW-1:0]        sus;
   logic [2*LW-1:0]      sl_prod;
   logic [LW-1:0]        mul_a;
   logic [LW-1:0]        lv;
   logic [LW+7:0]        vol_prod;
   logic [16:0]          atk_dec;
   logic [6:0]           vol_sat;

   assign cur  = idx_ff[VW-1:0];
   assign last = (idx_ff == (VW+1)'(VOICES - 1));
   assign busy = (state_ff != IDLE);
   assign csr_ready = 1'b1;

   vas_voice_ram #(.VOICES(VOICES), .AW(VW)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (cur),
      .rd_data (ram_rdata)
   );

   vas_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // first free voice
   always_comb begin
      has_free = 1'b0;
      free_idx = '0;
      for (int i = VOICES - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            has_free = 1'b1;
            free_idx = VW'(i);
         end
      end
   end

   // sustain level and shared arithmetic
   always_comb begin
      sus      = vas_pkg::sustain_of((sustain_ff > vas_pkg::SUSTAIN_MAX) ?
                                     vas_pkg::SUSTAIN_MAX : sustain_ff);
      sl_prod  = base_ff * sus;
      atk_dec  = {1'b0, attack_ff} + {1'b0, decay_ff};
      case (mode_ff)
         MODE_REL: mul_a = sl_ff;
         MODE_DEC: mul_a = base_ff - sl_ff;
         default:  mul_a = base_ff;
      endcase
      case (mode_ff)
         MODE_ZERO: lv = '0;
         MODE_SUS:  lv = sl_ff;
         MODE_DEC:  lv = base_ff - div_rsp.quotient;
         default:   lv = div_rsp.quotient;
      endcase
      vol_prod = best_ff * 8'(FULL_VOLUME);
      vol_sat  = (vol_prod[LW+7:16] > 9'd127) ? 7'd127 : vol_prod[22:16];
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      idx_in         = idx_ff;
      cand_in        = cand_ff;
      oldest_in      = oldest_ff;
      active_in      = active_ff;
      released_in    = released_ff;
      ch_in          = ch_ff;
      freq_in        = freq_ff;
      vel_in         = vel_ff;
      now_in         = now_ff;
      base_in        = base_ff;
      sl_in          = sl_ff;
      e_in           = e_ff;
      r_in           = r_ff;
      cur_freq_in    = cur_freq_ff;
      cur_ch_in      = cur_ch_ff;
      opb_in         = opb_ff;
      dsr_in         = dsr_ff;
      num_in         = num_ff;
      best_in        = best_ff;
      best_freq_in   = best_freq_ff;
      best_ch_in     = best_ch_ff;
      rsp_valid_in   = 1'b0;
      rsp_playing_in = rsp_playing_ff;
      rsp_freq_in    = rsp_freq_ff;
      rsp_vol_in     = rsp_vol_ff;
      rsp_ch_in      = rsp_ch_ff;
      ram_we         = 1'b0;
      ram_waddr      = cur;
      ram_wdata      = ram_rdata;
      div_req.start    = 1'b0;
      div_req.dividend = num_ff;
      div_req.divisor  = dsr_ff;

      unique case (state_ff)
         IDLE: begin
            if (start) begin
               ch_in     = req_channel;
               freq_in   = vas_pkg::FREQ_ROM[req_note];
               vel_in    = (req_velocity > 8'(VELOCITY_LIMIT)) ?
                           8'(VELOCITY_LIMIT) : req_velocity;
               now_in    = req_now_ms;
               idx_in    = '0;
               best_in      = '0;
               best_freq_in = '0;
               best_ch_in   = '0;
               unique case (req_func)
                  vas_pkg::FUNC_NOTE_ON: begin
                     if ({1'b0, req_channel} >= 5'(CHANNELS)) begin
                        state_in = IDLE;
                     end else if (has_free) begin
                        cand_in  = free_idx;
                        state_in = ON_WR;
                     end else begin
                        cand_in  = '0;
                        state_in = OLD_RD;
                     end
                  end
                  vas_pkg::FUNC_NOTE_OFF: state_in = OFF_RD;
                  vas_pkg::FUNC_ALL_OFF: begin
                     active_in   = '0;
                     released_in = '0;
                     state_in    = SEL_RD;
                  end
                  default: state_in = TICK_RD;
               endcase
            end
         end

         // oldest start time, first on ties
         OLD_RD: state_in = OLD_CMP;
         OLD_CMP: begin
            if (idx_ff == '0 || ram_rdata.start_ms < oldest_ff) begin
               cand_in   = cur;
               oldest_in = ram_rdata.start_ms;
            end
            idx_in   = idx_ff + (VW+1)'(1);
            state_in = last ? ON_WR : OLD_RD;
         end

         ON_WR: begin
            ram_we               = 1'b1;
            ram_waddr            = cand_ff;
            ram_wdata.frequency  = freq_ff;
            ram_wdata.velocity   = vel_ff;
            ram_wdata.channel    = ch_ff;
            ram_wdata.start_ms   = now_ff;
            ram_wdata.release_ms = '0;
            active_in[cand_ff]   = 1'b1;
            released_in[cand_ff] = 1'b0;
            idx_in               = '0;
            state_in             = SEL_RD;
         end

         // release the first matching voice
         OFF_RD: state_in = OFF_CMP;
         OFF_CMP: begin
            if (active_ff[cur] && ram_rdata.channel == ch_ff &&
                ram_rdata.frequency == freq_ff) begin
               ram_we               = 1'b1;
               ram_wdata.release_ms = now_ff;
               released_in[cur]     = 1'b1;
               idx_in               = '0;
               state_in             = SEL_RD;
            end else if (last) begin
               idx_in   = '0;
               state_in = SEL_RD;
            end else begin
               idx_in   = idx_ff + (VW+1)'(1);
               state_in = OFF_RD;
            end
         end

         // free voices whose release has run out
         TICK_RD: state_in = TICK_CMP;
         TICK_CMP: begin
            if (active_ff[cur] && released_ff[cur] &&
                (now_ff - ram_rdata.release_ms) >= {16'd0, release_ff}) begin
               active_in[cur] = 1'b0;
            end
            if (last) begin
               idx_in   = '0;
               state_in = SEL_RD;
            end else begin
               idx_in   = idx_ff + (VW+1)'(1);
               state_in = TICK_RD;
            end
         end

         // loudest-voice scan
         SEL_RD: begin
            if (active_ff[cur]) begin
               state_in = SEL_LOAD;
            end else if (last) begin
               state_in = SEL_VOL;
            end else begin
               idx_in = idx_ff + (VW+1)'(1);
            end
         end
         SEL_LOAD: begin
            base_in     = vas_pkg::base_of(ram_rdata.velocity);
            e_in        = now_ff - ram_rdata.start_ms;
            r_in        = now_ff - ram_rdata.release_ms;
            cur_freq_in = ram_rdata.frequency;
            cur_ch_in   = ram_rdata.channel;
            state_in    = SEL_SL;
         end
         SEL_SL: begin
            sl_in = sl_prod[LW+15:16];
            if (released_ff[cur]) begin
               if (r_ff >= {16'd0, release_ff}) begin
                  mode_in = MODE_ZERO;
               end else begin
                  mode_in = MODE_REL;
                  opb_in  = release_ff - r_ff[15:0];
                  dsr_in  = release_ff;
               end
            end else if (e_ff < {16'd0, attack_ff}) begin
               mode_in = MODE_ATK;
               opb_in  = e_ff[15:0];
               dsr_in  = attack_ff;
            end else if (e_ff < {15'd0, atk_dec}) begin
               mode_in = MODE_DEC;
               opb_in  = e_ff[15:0] - attack_ff;
               dsr_in  = decay_ff;
            end else begin
               mode_in = MODE_SUS;
            end
            state_in = SEL_MUL;
         end
         SEL_MUL: begin
            num_in   = mul_a * opb_ff;
            state_in = (mode_ff == MODE_ZERO || mode_ff == MODE_SUS) ? SEL_FIN : SEL_DIVGO;
         end
         SEL_DIVGO: begin
            div_req.start = 1'b1;
            state_in      = SEL_DIV;
         end
         SEL_DIV: begin
            if (div_rsp.done) begin
               state_in = SEL_FIN;
            end
         end
         SEL_FIN: begin
            if (lv > best_ff) begin
               best_in      = lv;
               best_freq_in = cur_freq_ff;
               best_ch_in   = cur_ch_ff;
            end
            if (last) begin
               state_in = SEL_VOL;
            end else begin
               idx_in   = idx_ff + (VW+1)'(1);
               state_in = SEL_RD;
            end
         end

         // scale to full volume and post the result
         SEL_VOL: begin
            rsp_valid_in = 1'b1;
            if (best_freq_ff != '0 && vol_sat != '0) begin
               rsp_playing_in = 1'b1;
               rsp_freq_in    = best_freq_ff;
               rsp_vol_in     = vol_sat;
               rsp_ch_in      = best_ch_ff;
            end else begin
               rsp_playing_in = 1'b0;
               rsp_freq_in    = '0;
               rsp_vol_in     = '0;
               rsp_ch_in      = '0;
            end
            state_in = IDLE;
         end

         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= IDLE;
         active_ff      <= '0;
         released_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
         rsp_playing_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         active_ff      <= active_in;
         released_ff    <= released_in;
         rsp_valid_ff   <= rsp_valid_in;
         rsp_playing_ff <= rsp_playing_in;
      end
      mode_ff      <= mode_in;
      idx_ff       <= idx_in;
      cand_ff      <= cand_in;
      oldest_ff    <= oldest_in;
      ch_ff        <= ch_in;
      freq_ff      <= freq_in;
      vel_ff       <= vel_in;
      now_ff       <= now_in;
      base_ff      <= base_in;
      sl_ff        <= sl_in;
      e_ff         <= e_in;
      r_ff         <= r_in;
      cur_freq_ff  <= cur_freq_in;
      cur_ch_ff    <= cur_ch_in;
      opb_ff       <= opb_in;
      dsr_ff       <= dsr_in;
      num_ff       <= num_in;
      best_ff      <= best_in;
      best_freq_ff <= best_freq_in;
      best_ch_ff   <= best_ch_in;
      rsp_freq_ff  <= rsp_freq_in;
      rsp_vol_ff   <= rsp_vol_in;
      rsp_ch_ff    <= rsp_ch_in;
   end

   // envelope registers
   always_ff @(posedge clock) begin
      if (reset) begin
         attack_ff  <= vas_pkg::ATTACK_RESET;
         decay_ff   <= vas_pkg::DECAY_RESET;
         sustain_ff <= vas_pkg::SUSTAIN_RESET;
         release_ff <= vas_pkg::RELEASE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            vas_pkg::CSR_ATTACK:  attack_ff  <= csr_data;
            vas_pkg::CSR_DECAY:   decay_ff   <= csr_data;
            vas_pkg::CSR_SUSTAIN: sustain_ff <= csr_data[3:0];
            default:              release_ff <= csr_data;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_playing     = rsp_playing_ff;
   assign rsp_frequency   = rsp_freq_ff;
   assign rsp_volume      = rsp_vol_ff;
   assign rsp_channel_out = rsp_ch_ff;

endmodule

### design/vas_checker.sv
`include "voice_allocator_adsr_loudest_select_defines.svh"

module vas_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [1:0]  req_func,
   input logic        rsp_valid,
   input logic        rsp_playing,
   input logic [13:0] rsp_frequency,
   input logic [6:0]  rsp_volume,
   input logic [3:0]  rsp_channel_out
);

   // result strobe is a single-cycle pulse
   `VAS_ASSERT_ALWAYS(a_strobe_single, clock, rsp_valid |=> !rsp_valid, "result strobe held")

   // a result only closes a transaction in flight
   `VAS_ASSERT(a_rsp_after_busy, clock, reset, rsp_valid |-> $past(busy), "result while idle")

   // a stopped result carries all-zero fields
   `VAS_ASSERT(a_stopped_zero, clock, reset,
      rsp_valid && !rsp_playing |-> rsp_frequency == 14'd0 && rsp_volume == 7'd0 &&
         rsp_channel_out == 4'd0,
      "stopped result with nonzero fields")

   // a playing result has sound
   `VAS_ASSERT(a_playing_sound, clock, reset,
      rsp_valid && rsp_playing |-> rsp_frequency != 14'd0 && rsp_volume != 7'd0,
      "playing result without sound")

   // every accepted event other than note on starts work
   `VAS_ASSERT(a_accept_busy, clock, reset,
      start && !busy && req_func != vas_pkg::FUNC_NOTE_ON |=> busy, "event not taken")

endmodule

bind voice_allocator_adsr_loudest_select vas_checker u_vas_checker (.*);

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;

   localparam int NUM_VOICES  = 8;
   localparam int VOLUME_FULL = 100;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int RAND_PHASES = 6;
   localparam int PHASE_ITEMS = 275;

   typedef struct packed {
      logic        playing;
      logic [13:0] frequency;
      logic [6:0]  volume;
      logic [3:0]  channel;
   } tone_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [3:0]  channel;
      logic [6:0]  note;
      logic [7:0]  velocity;
      logic [31:0] now_ms;
      logic        pinned;
      tone_type    tone;
   } event_row_type;

   localparam tone_type SILENT = '{1'b0, 14'd0, 7'd0, 4'd0};

   // directed events, default envelope; pinned rows carry a hand-derived result
   event_row_type dir_tab [24] = '{
      '{vas_pkg::FUNC_ALL_OFF, 4'd0, 7'd0, 8'd0, 32'd0, 1'b1, SILENT},
      '{vas_pkg::FUNC_TICK, 4'd0, 7'd0, 8'd0, 32'd5, 1'b1, SILENT},
      '{vas_pkg::FUNC_NOTE_ON, 4'd3, 7'd69, 8'd127, 32'd1000, 1'b1, SILENT},
      '{vas_pkg::FUNC_TICK, 4'd0, 7'd0, 8'd0, 32'd1050, 1'b1,
        '{1'b1, 14'd440, 7'd100, 4'd3}},
      '{vas_pkg::FUNC_TICK, 4'd0, 7'd0, 8'd0, 32'd1150, 1'b1,
        '{1'b1, 14'd440, 7'd69, 4'd3}},
      '{vas_pkg::FUNC_NOTE_ON, 4'd15, 7'd127, 8'd255, 32'd1200, 1'b1,
        '{1'b1, 14'd440, 7'd69, 4'd3}},
      '{vas_pkg::FUNC_TICK, 4'd0, 7'd0, 8'd0, 32'd1250, 1'b1,
        '{1'b1, 14'd12543, 7'd100, 4'd15}},
      '{vas_pkg::FUNC_NOTE_ON, 4'd0, 7'd0, 8'd127, 32'd1260, 1'b0, SILENT},
      '{vas_pkg::FUNC_NOTE_OFF, 4'd3, 7'd69, 8'd0, 32'd1300, 1'b0, SILENT},
      '{vas_pkg::FUNC_TICK, 4'd0, 7'd0, 8'd0, 32'd1600, 1'b0, SILENT},
      '{vas_pkg::FUNC_NOTE_ON, 4'd7, 7'd60, 8'd0, 32'd1700, 1'b0, SILENT},
      '{vas_pkg::FUNC_NOTE_OFF, 4'd5, 7'd1, 8'd0, 32'd1710, 1'b0, SILENT},
      '{vas_pkg::FUNC_NOTE_ON, 4'd1, 7'd2, 8'd100, 32'd1720, 1'b0, SILENT},
      '{vas_pkg::FUNC_NOTE_ON, 4'd1, 7'd3, 8'd90, 32'd1730, 1'b0, SILENT},
      '{vas_pkg::FUNC_NOTE_ON, 4'd2, 7'd30, 8'd1, 32'd1740, 1'b0, SILENT},
      '{vas_pkg::FUNC_NOTE_ON, 4'd4, 7'd100, 8'd64, 32'd1750, 1'b0, SILENT},
      '{vas_pkg::FUNC_NOTE_ON, 4'd6, 7'd80, 8'd128, 32'd1760, 1'b0, SILENT},
      '{vas_pkg::FUNC_NOTE_ON, 4'd8, 7'd40, 8'd127, 32'd1770, 1'b0, SILENT},
      '{vas_pkg::FUNC_NOTE_ON, 4'd9, 7'd50, 8'd127, 32'd1780, 1'b0, SILENT},
      '{vas_pkg::FUNC_NOTE_OFF, 4'd1, 7'd3, 8'd0, 32'd1790, 1'b0, SILENT},
      '{vas_pkg::FUNC_NOTE_ON, 4'd10, 7'd120, 8'd127, 32'hFFFFFFFF, 1'b0, SILENT},
      '{vas_pkg::FUNC_TICK, 4'd0, 7'd0, 8'd0, 32'h00000010, 1'b0, SILENT},
      '{vas_pkg::FUNC_ALL_OFF, 4'd0, 7'd0, 8'd0, 32'h00000020, 1'b1, SILENT},
      '{vas_pkg::FUNC_TICK, 4'd0, 7'd0, 8'd0, 32'h00000030, 1'b1, SILENT}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_func = vas_pkg::FUNC_TICK;
   logic [3:0]  req_channel = '0;
   logic [6:0]  req_note = '0;
   logic [7:0]  req_velocity = '0;
   logic [31:0] req_now_ms = '0;
   logic        rsp_valid;
   logic        rsp_playing;
   logic [13:0] rsp_frequency;
   logic [6:0]  rsp_volume;
   logic [3:0]  rsp_channel_out;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = vas_pkg::CSR_ATTACK;
   logic [15:0] csr_data = '0;

   // hand-derived result riding along with the event it belongs to
   logic        pin_use = 1'b0;
   tone_type    pin_tone = SILENT;

   voice_allocator_adsr_loudest_select u_dut (
      .clock, .reset, .start, .busy,
      .req_func, .req_channel, .req_note, .req_velocity, .req_now_ms,
      .rsp_valid, .rsp_playing, .rsp_frequency, .rsp_volume, .rsp_channel_out,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // envelope settings and voice table mirror
   logic [15:0] env_attack, env_decay, env_release;
   logic [3:0]  env_sustain;
   logic        v_active   [NUM_VOICES];
   logic        v_released [NUM_VOICES];
   logic [13:0] v_freq     [NUM_VOICES];
   logic [6:0]  v_vel      [NUM_VOICES];
   logic [3:0]  v_chan     [NUM_VOICES];
   logic [31:0] v_start    [NUM_VOICES];
   logic [31:0] v_rel      [NUM_VOICES];

   tone_type tone_q [$];
   int    mismatches = 0;
   int    cycles = 0;

   // Q1.16 envelope level of one voice at time now
   function automatic longint unsigned envelope_level(int v, logic [31:0] now);
      longint unsigned base, sus, sl, tenths;
      logic [31:0] e, r;
      base   = ({57'd0, v_vel[v]} << 16) / 127;
      tenths = (env_sustain > 4'd10) ? 10 : env_sustain;
      sus    = (tenths << 16) / 10;
      if (base > 64'h1FFFF) base = 64'h1FFFF;
      sl = (base * sus) >> 16;
      if (v_released[v]) begin
         r = now - v_rel[v];
         if (r >= {16'd0, env_release}) return 0;
         return sl * (env_release - r) / env_release;
      end
      e = now - v_start[v];
      if (e < {16'd0, env_attack}) return base * e / env_attack;
      if (e < {16'd0, env_attack} + {16'd0, env_decay})
         return base - (base - sl) * (e - env_attack) / env_decay;
      return sl;
   endfunction

   // apply one event to the voice table and return the loudest-voice tone
   task automatic voice_event(input logic [1:0] func, input logic [3:0] ch,
                              input logic [6:0] note, input logic [7:0] vel,
                              input logic [31:0] now, output tone_type tone);
      int slot;
      longint unsigned best, lv, vol;
      logic [31:0] elapsed;
      tone = SILENT;
      best = 0;
      case (func)
         vas_pkg::FUNC_NOTE_ON: begin
            slot = -1;
            for (int i = 0; i < NUM_VOICES; i++)
               if (slot < 0 && !v_active[i]) slot = i;
            if (slot < 0) begin
               slot = 0;
               for (int i = 1; i < NUM_VOICES; i++)
                  if (v_start[i] < v_start[slot]) slot = i;
            end
            v_freq[slot]     = vas_pkg::FREQ_ROM[note];
            v_vel[slot]      = (vel > 8'd127) ? 7'd127 : vel[6:0];
            v_chan[slot]     = ch;
            v_start[slot]    = now;
            v_rel[slot]      = '0;
            v_active[slot]   = 1'b1;
            v_released[slot] = 1'b0;
         end
         vas_pkg::FUNC_NOTE_OFF: begin
            slot = -1;
            for (int i = 0; i < NUM_VOICES; i++)
               if (slot < 0 && v_active[i] && v_chan[i] == ch &&
                   v_freq[i] == vas_pkg::FREQ_ROM[note])
                  slot = i;
            if (slot >= 0) begin
               v_released[slot] = 1'b1;
               v_rel[slot]      = now;
            end
         end
         vas_pkg::FUNC_ALL_OFF: begin
            for (int i = 0; i < NUM_VOICES; i++) begin
               v_active[i]   = 1'b0;
               v_released[i] = 1'b0;
            end
         end
         default: begin
            for (int i = 0; i < NUM_VOICES; i++) begin
               elapsed = now - v_rel[i];
               if (v_active[i] && v_released[i] && elapsed >= {16'd0, env_release})
                  v_active[i] = 1'b0;
            end
         end
      endcase
      // loudest voice, first one wins ties
      for (int i = 0; i < NUM_VOICES; i++) begin
         if (v_active[i]) begin
            lv = envelope_level(i, now);
            if (lv > best) begin
               best = lv;
               vol  = (lv * VOLUME_FULL) >> 16;
               tone = '{1'b1, v_freq[i], (vol > 127) ? 7'd127 : vol[6:0], v_chan[i]};
            end
         end
      end
      if (tone.frequency == 0 || tone.volume == 0) tone = SILENT;
   endtask

   // monitor: check results, then predict newly accepted transactions
   always @(posedge clock) begin
      tone_type got, want;
      cycles <= cycles + 1;
      if (reset) begin
         env_attack  <= vas_pkg::ATTACK_RESET;
         env_decay   <= vas_pkg::DECAY_RESET;
         env_sustain <= vas_pkg::SUSTAIN_RESET;
         env_release <= vas_pkg::RELEASE_RESET;
         for (int i = 0; i < NUM_VOICES; i++) begin
            v_active[i] = 1'b0; v_released[i] = 1'b0;
            v_chan[i] = '0; v_start[i] = '0; v_rel[i] = '0;
         end
      end else begin
         if (rsp_valid) begin
            got = '{rsp_playing, rsp_frequency, rsp_volume, rsp_channel_out};
            if (tone_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
               want = tone_q.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result mismatch: expected %p, got %p", want, got);
               end
            end
         end
         if (start && !busy) begin
            voice_event(req_func, req_channel, req_note, req_velocity, req_now_ms, want);
            tone_q.push_back(pin_use ? pin_tone : want);
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               vas_pkg::CSR_ATTACK:  env_attack  <= csr_data;
               vas_pkg::CSR_DECAY:   env_decay   <= csr_data;
               vas_pkg::CSR_SUSTAIN: env_sustain <= csr_data[3:0];
               default:              env_release <= csr_data;
            endcase
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("** voice_allocator_adsr_loudest_select: FAILED **");
         $finish;
      end
   end

   // issue one event transaction, optionally after an idle gap
   task automatic send_event(input logic [1:0] func, input logic [3:0] ch,
                             input logic [6:0] note, input logic [7:0] vel,
                             input logic [31:0] now, input bit pinned,
                             input tone_type tone, input bit gap);
      if (gap) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_func     <= func;
      req_channel  <= ch;
      req_note     <= note;
      req_velocity <= vel;
      req_now_ms   <= now;
      pin_use      <= pinned;
      pin_tone     <= tone;
      start        <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   // register write on an idle block
   task automatic csr_write(input logic [1:0] idx, input logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // wait until the last accepted transaction is queued, then empty the queue
   task automatic drain;
      start <= 1'b0;
      @(posedge clock);
      while (tone_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_duration();
      case ($urandom_range(0, 9))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         default: return 16'($urandom_range(1, 400));
      endcase
   endfunction

   // stimulus
   initial begin
      logic [31:0] now;
      logic [1:0]  func;
      logic [3:0]  ch;
      logic [6:0]  note;
      logic [10:0] held [$];
      int          pick;
      bit          gap;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part
      foreach (dir_tab[i])
         send_event(dir_tab[i].func, dir_tab[i].channel, dir_tab[i].note,
                    dir_tab[i].velocity, dir_tab[i].now_ms, dir_tab[i].pinned,
                    dir_tab[i].tone, 1'b0);
      drain();

      // random phases; phase 0 keeps reset settings and never idles
      now = 32'd100;
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         if (ph == 1) begin
            csr_write(vas_pkg::CSR_ATTACK, 16'd0);
            csr_write(vas_pkg::CSR_DECAY, 16'd0);
            csr_write(vas_pkg::CSR_SUSTAIN, 16'd15);
            csr_write(vas_pkg::CSR_RELEASE, 16'd0);
         end else if (ph == 2) begin
            csr_write(vas_pkg::CSR_ATTACK, 16'hFFFF);
            csr_write(vas_pkg::CSR_DECAY, 16'hFFFF);
            csr_write(vas_pkg::CSR_SUSTAIN, 16'd0);
            csr_write(vas_pkg::CSR_RELEASE, 16'hFFFF);
         end else if (ph > 2) begin
            csr_write(vas_pkg::CSR_ATTACK, pick_duration());
            csr_write(vas_pkg::CSR_DECAY, pick_duration());
            csr_write(vas_pkg::CSR_SUSTAIN, 16'($urandom_range(0, 15)));
            csr_write(vas_pkg::CSR_RELEASE, pick_duration());
         end
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if ($urandom_range(0, 99) < 3) now = $urandom;
            else now = now + $urandom_range(0, 300);
            ch   = 4'($urandom);
            note = 7'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 35) func = vas_pkg::FUNC_NOTE_ON;
            else if (pick < 60) func = vas_pkg::FUNC_NOTE_OFF;
            else if (pick < 95) func = vas_pkg::FUNC_TICK;
            else func = vas_pkg::FUNC_ALL_OFF;
            // most note offs target a held note
            if (func == vas_pkg::FUNC_NOTE_OFF && held.size() > 0 &&
                $urandom_range(0, 3) != 0)
               {ch, note} = held[$urandom_range(0, held.size() - 1)];
            if (func == vas_pkg::FUNC_NOTE_ON) begin
               held.push_back({ch, note});
               if (held.size() > 16) void'(held.pop_front());
            end
            gap = (ph != 0) && ($urandom_range(0, 99) < 17);
            send_event(func, ch, note, 8'($urandom), now, 1'b0, SILENT, gap);
         end
         drain();
      end

      repeat (50) @(posedge clock);
      if (mismatches == 0 && tone_q.size() == 0) begin
         $display("** voice_allocator_adsr_loudest_select: PASSED **");
      end else begin
         $display("** voice_allocator_adsr_loudest_select: FAILED **");
      end
      $finish;
   end

endmodule

### voice_allocator_adsr_loudest_select.f
+incdir+design
design/vas_pkg.sv
design/vas_voice_ram.sv
design/vas_divider.sv
design/voice_allocator_adsr_loudest_select.sv
design/vas_checker.sv
tb/sv/tb.sv
